>>> hdl/c2q_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and arithmetic helpers for the cubic to quadratics splitter.
package c2q_pkg;

  localparam int CW   = 32;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int LW   = DW + 1;
  localparam int HW   = PW - LW;
  localparam int NW   = DW + PW;
  localparam int QW   = CW;
  localparam int NPRE = 9;
  localparam int NS   = NPRE + QW + 1;
  localparam int NL   = 4;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [DW-1:0]   diff_t;
  typedef logic signed [2*DW-1:0] prod_t;
  typedef logic signed [PW-1:0]   cross_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] quo;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    coord_t     ax0;
    coord_t     ay0;
    coord_t     ax1;
    coord_t     ay1;
    coord_t     px;
    coord_t     py;
    coord_t     fbx0;
    coord_t     fby0;
    coord_t     fbx1;
    coord_t     fby1;
    logic [1:0] meet;
  } side_t;

  function automatic coord_t mid(coord_t a, coord_t b);
    logic [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    return s[CW:1];
  endfunction

  function automatic diff_t sub(coord_t a, coord_t b);
    return diff_t'({a[CW-1], a} - {b[CW-1], b});
  endfunction

  function automatic coord_t sat(logic [CW+2:0] v);
    coord_t r;
    if ((v[CW+2:CW-1] == '0) || (v[CW+2:CW-1] == '1)) begin
      r = v[CW-1:0];
    end else if (v[CW+2]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hdl/cubic_to_two_quadratics.sv
`timescale 1ns / 1ps
// Pipelined splitter of one cubic Bezier into two quadratic Beziers.
//
// One cubic enters per cycle while the output is not stalled, and its result word passes through
// NS = 42 register stages in all. The depth of the pipeline is set by the
// exact quotient of the control point: after nine stages of midpoints, cross products and
// magnitudes, a restoring divider resolves one quotient bit per stage over 32 stages, then
// one stage adds and saturates.
// A held output word stalls the whole pipeline; no word is lost or repeated.
module cubic_to_two_quadratics import c2q_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [CW-1:0] start_x_i,
  input  logic [CW-1:0] start_y_i,
  input  logic [CW-1:0] near_ctrl_x_i,
  input  logic [CW-1:0] near_ctrl_y_i,
  input  logic [CW-1:0] far_ctrl_x_i,
  input  logic [CW-1:0] far_ctrl_y_i,
  input  logic [CW-1:0] end_x_i,
  input  logic [CW-1:0] end_y_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [CW-1:0] first_ctrl_x_o,
  output logic [CW-1:0] first_ctrl_y_o,
  output logic [CW-1:0] split_x_o,
  output logic [CW-1:0] split_y_o,
  output logic [CW-1:0] second_ctrl_x_o,
  output logic [CW-1:0] second_ctrl_y_o,
  output logic         first_fallback_o,
  output logic         second_fallback_o
);

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t nx;
    coord_t ny;
    coord_t fx;
    coord_t fy;
    coord_t ex;
    coord_t ey;
  } pts_t;

  logic [NS-1:0] v_q;
  logic          en;

  pts_t   pts0_q, pts1_q;
  coord_t m0x_q, m0y_q, m1x_q, m1y_q, m2x_q, m2y_q;
  coord_t t0x_q, t0y_q, t1x_q, t1y_q;

  coord_t ax2_q [2];
  coord_t ay2_q [2];
  diff_t  rdx2_q [2];
  diff_t  rdy2_q [2];
  diff_t  ldx2_q [2];
  diff_t  ldy2_q [2];
  diff_t  ofx2_q [2];
  diff_t  ofy2_q [2];
  coord_t px2_q, py2_q;

  coord_t ax3_q [2];
  coord_t ay3_q [2];
  diff_t  rdx3_q [2];
  diff_t  rdy3_q [2];
  prod_t  pa3_q [2];
  prod_t  pb3_q [2];
  prod_t  pc3_q [2];
  prod_t  pd3_q [2];
  prod_t  pe3_q [2];
  prod_t  pf3_q [2];
  coord_t px3_q, py3_q;
  coord_t fbx3_q [2];
  coord_t fby3_q [2];

  coord_t ax4_q [2];
  coord_t ay4_q [2];
  diff_t  rdx4_q [2];
  diff_t  rdy4_q [2];
  cross_t det4_q [2];
  cross_t nu4_q [2];
  cross_t nv4_q [2];
  coord_t px4_q, py4_q;
  coord_t fbx4_q [2];
  coord_t fby4_q [2];

  logic signed [DW+LW:0]   lox5_q [2];
  logic signed [DW+LW:0]   loy5_q [2];
  logic signed [DW+HW-1:0] hix5_q [2];
  logic signed [DW+HW-1:0] hiy5_q [2];
  cross_t det5_q [2];
  cross_t det6_q [2];
  logic signed [NW-1:0] nx6_q [2];
  logic signed [NW-1:0] ny6_q [2];

  lane_t        ln7_q [NL];
  logic [PW-1:0] den7_q [2];

  side_t         sd_q [5:NS-2];
  lane_t         dl_q [QW+1][NL];
  logic [PW-1:0] dd_q [QW+1][2];

  coord_t res_x_q [2];
  coord_t res_y_q [2];
  coord_t spl_x_q, spl_y_q;
  logic [1:0] fb_q;

  assign en         = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pts0_q <= '{start_x_i, start_y_i, near_ctrl_x_i, near_ctrl_y_i,
                  far_ctrl_x_i, far_ctrl_y_i, end_x_i, end_y_i};
      m0x_q  <= mid(start_x_i, near_ctrl_x_i);
      m0y_q  <= mid(start_y_i, near_ctrl_y_i);
      m1x_q  <= mid(near_ctrl_x_i, far_ctrl_x_i);
      m1y_q  <= mid(near_ctrl_y_i, far_ctrl_y_i);
      m2x_q  <= mid(far_ctrl_x_i, end_x_i);
      m2y_q  <= mid(far_ctrl_y_i, end_y_i);

      pts1_q <= pts0_q;
      t0x_q  <= mid(m0x_q, m1x_q);
      t0y_q  <= mid(m0y_q, m1y_q);
      t1x_q  <= mid(m1x_q, m2x_q);
      t1y_q  <= mid(m1y_q, m2y_q);

      ax2_q[0]  <= pts1_q.sx;
      ay2_q[0]  <= pts1_q.sy;
      rdx2_q[0] <= sub(pts1_q.nx, pts1_q.sx);
      rdy2_q[0] <= sub(pts1_q.ny, pts1_q.sy);
      ldx2_q[0] <= sub(t0x_q, t1x_q);
      ldy2_q[0] <= sub(t0y_q, t1y_q);
      ofx2_q[0] <= sub(t1x_q, pts1_q.sx);
      ofy2_q[0] <= sub(t1y_q, pts1_q.sy);
      ax2_q[1]  <= pts1_q.ex;
      ay2_q[1]  <= pts1_q.ey;
      rdx2_q[1] <= sub(pts1_q.fx, pts1_q.ex);
      rdy2_q[1] <= sub(pts1_q.fy, pts1_q.ey);
      ldx2_q[1] <= sub(t1x_q, t0x_q);
      ldy2_q[1] <= sub(t1y_q, t0y_q);
      ofx2_q[1] <= sub(t0x_q, pts1_q.ex);
      ofy2_q[1] <= sub(t0y_q, pts1_q.ey);
      px2_q     <= mid(t0x_q, t1x_q);
      py2_q     <= mid(t0y_q, t1y_q);

      for (int h = 0; h < 2; h++) begin
        ax3_q[h]  <= ax2_q[h];
        ay3_q[h]  <= ay2_q[h];
        rdx3_q[h] <= rdx2_q[h];
        rdy3_q[h] <= rdy2_q[h];
        pa3_q[h]  <= ldx2_q[h] * rdy2_q[h];
        pb3_q[h]  <= ldy2_q[h] * rdx2_q[h];
        pc3_q[h]  <= ofy2_q[h] * ldx2_q[h];
        pd3_q[h]  <= ofx2_q[h] * ldy2_q[h];
        pe3_q[h]  <= ofy2_q[h] * rdx2_q[h];
        pf3_q[h]  <= ofx2_q[h] * rdy2_q[h];
      end
      px3_q     <= px2_q;
      py3_q     <= py2_q;
      fbx3_q[0] <= mid(ax2_q[0], px2_q);
      fby3_q[0] <= mid(ay2_q[0], py2_q);
      fbx3_q[1] <= mid(px2_q, ax2_q[1]);
      fby3_q[1] <= mid(py2_q, ay2_q[1]);

      for (int h = 0; h < 2; h++) begin
        ax4_q[h]  <= ax3_q[h];
        ay4_q[h]  <= ay3_q[h];
        rdx4_q[h] <= rdx3_q[h];
        rdy4_q[h] <= rdy3_q[h];
        det4_q[h] <= cross_t'(pa3_q[h]) - cross_t'(pb3_q[h]);
        nu4_q[h]  <= cross_t'(pc3_q[h]) - cross_t'(pd3_q[h]);
        nv4_q[h]  <= cross_t'(pe3_q[h]) - cross_t'(pf3_q[h]);
        fbx4_q[h] <= fbx3_q[h];
        fby4_q[h] <= fby3_q[h];
      end
      px4_q <= px3_q;
      py4_q <= py3_q;

      for (int h = 0; h < 2; h++) begin
        lox5_q[h] <= rdx4_q[h] * $signed({1'b0, nu4_q[h][LW-1:0]});
        loy5_q[h] <= rdy4_q[h] * $signed({1'b0, nu4_q[h][LW-1:0]});
        hix5_q[h] <= rdx4_q[h] * $signed(nu4_q[h][PW-1:LW]);
        hiy5_q[h] <= rdy4_q[h] * $signed(nu4_q[h][PW-1:LW]);
        det5_q[h] <= det4_q[h];
        sd_q[5].meet[h] <= (det4_q[h] != '0) && (nu4_q[h] != '0) && (nv4_q[h] != '0) &&
                           (nu4_q[h][PW-1] == det4_q[h][PW-1]) &&
                           (nv4_q[h][PW-1] == det4_q[h][PW-1]);
      end
      sd_q[5].ax0  <= ax4_q[0];
      sd_q[5].ay0  <= ay4_q[0];
      sd_q[5].ax1  <= ax4_q[1];
      sd_q[5].ay1  <= ay4_q[1];
      sd_q[5].px   <= px4_q;
      sd_q[5].py   <= py4_q;
      sd_q[5].fbx0 <= fbx4_q[0];
      sd_q[5].fby0 <= fby4_q[0];
      sd_q[5].fbx1 <= fbx4_q[1];
      sd_q[5].fby1 <= fby4_q[1];

      for (int h = 0; h < 2; h++) begin
        nx6_q[h]  <= (NW'(hix5_q[h]) <<< LW) + NW'(lox5_q[h]);
        ny6_q[h]  <= (NW'(hiy5_q[h]) <<< LW) + NW'(loy5_q[h]);
        det6_q[h] <= det5_q[h];
      end

      for (int l = 0; l < NL; l++) begin
        if (l % 2 == 0) begin
          ln7_q[l].rem <= nx6_q[l/2][NW-1] ? NW'(-nx6_q[l/2]) : NW'(nx6_q[l/2]);
          ln7_q[l].neg <= nx6_q[l/2][NW-1] ^ det6_q[l/2][PW-1];
        end else begin
          ln7_q[l].rem <= ny6_q[l/2][NW-1] ? NW'(-ny6_q[l/2]) : NW'(ny6_q[l/2]);
          ln7_q[l].neg <= ny6_q[l/2][NW-1] ^ det6_q[l/2][PW-1];
        end
        ln7_q[l].quo <= '0;
        ln7_q[l].ovf <= 1'b0;
      end
      for (int h = 0; h < 2; h++) begin
        den7_q[h] <= det6_q[h][PW-1] ? PW'(-det6_q[h]) : PW'(det6_q[h]);
      end

      for (int l = 0; l < NL; l++) begin
        dl_q[0][l] <= '{rem: ln7_q[l].rem,
                        quo: ln7_q[l].quo,
                        ovf: ln7_q[l].rem >= NW'({den7_q[l/2], {QW{1'b0}}}),
                        neg: ln7_q[l].neg};
      end
      for (int h = 0; h < 2; h++) begin
        dd_q[0][h] <= den7_q[h];
      end

      sd_q[6] <= sd_q[5];
      sd_q[7] <= sd_q[6];
      sd_q[8] <= sd_q[7];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    always_ff @(posedge clk_i) begin
      lane_t nxt;
      if (en) begin
        for (int l = 0; l < NL; l++) begin
          nxt = dl_q[j][l];
          if (nxt.rem >= (NW'(dd_q[j][l/2]) << B)) begin
            nxt.rem    = nxt.rem - (NW'(dd_q[j][l/2]) << B);
            nxt.quo[B] = 1'b1;
          end
          dl_q[j+1][l] <= nxt;
        end
        dd_q[j+1]        <= dd_q[j];
        sd_q[NPRE + j]   <= sd_q[NPRE + j - 1];
      end
    end
  end

  function automatic coord_t finish(coord_t base, lane_t ln);
    logic [CW+1:0] sq;
    logic [CW+2:0] sum;
    coord_t        r;
    sq  = ln.neg ? (CW+2)'(-{2'b00, ln.quo}) : {2'b00, ln.quo};
    sum = {{3{base[CW-1]}}, base} + {sq[CW+1], sq};
    if (ln.ovf) begin
      r = ln.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = sat(sum);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_x_q[0] <= sd_q[NS-2].meet[0] ? finish(sd_q[NS-2].ax0, dl_q[QW][0])
                                       : sd_q[NS-2].fbx0;
      res_y_q[0] <= sd_q[NS-2].meet[0] ? finish(sd_q[NS-2].ay0, dl_q[QW][1])
                                       : sd_q[NS-2].fby0;
      res_x_q[1] <= sd_q[NS-2].meet[1] ? finish(sd_q[NS-2].ax1, dl_q[QW][2])
                                       : sd_q[NS-2].fbx1;
      res_y_q[1] <= sd_q[NS-2].meet[1] ? finish(sd_q[NS-2].ay1, dl_q[QW][3])
                                       : sd_q[NS-2].fby1;
      spl_x_q    <= sd_q[NS-2].px;
      spl_y_q    <= sd_q[NS-2].py;
      fb_q       <= ~sd_q[NS-2].meet;
    end
  end

  assign out_valid_o       = v_q[NS-1];
  assign first_ctrl_x_o    = res_x_q[0];
  assign first_ctrl_y_o    = res_y_q[0];
  assign split_x_o         = spl_x_q;
  assign split_y_o         = spl_y_q;
  assign second_ctrl_x_o   = res_x_q[1];
  assign second_ctrl_y_o   = res_y_q[1];
  assign first_fallback_o  = fb_q[0];
  assign second_fallback_o = fb_q[1];

  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-2] && !dl_q[QW][0].ovf |-> dl_q[QW][0].rem < NW'(dd_q[QW][0]))
    else $error("divider remainder not below divisor");

  a_meet_has_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NPRE-2] && sd_q[NPRE-2].meet[1] |-> den7_q[1] != '0)
    else $error("intersection taken with zero determinant");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word did not enter the pipeline");

endmodule

>>> tb/cubic_to_two_quadratics_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cubic to quadratics splitter with random stalls on both sides.
module cubic_to_two_quadratics_test;
  import c2q_pkg::*;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    coord_t sx, sy, nx, ny, fx, fy, ex, ey;
  } cubic_t;

  typedef struct packed {
    coord_t c1x, c1y, px, py, c2x, c2y;
    logic   fb1, fb2;
  } quads_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  cubic_t curve_d = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  quads_t got;

  cubic_t pending_curves[$];
  quads_t expected_quads[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     took = 1'b0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_mode = 0;

  cubic_to_two_quadratics u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .start_x_i(curve_d.sx), .start_y_i(curve_d.sy),
    .near_ctrl_x_i(curve_d.nx), .near_ctrl_y_i(curve_d.ny),
    .far_ctrl_x_i(curve_d.fx), .far_ctrl_y_i(curve_d.fy),
    .end_x_i(curve_d.ex), .end_y_i(curve_d.ey),
    .out_valid_o, .out_ready_i,
    .first_ctrl_x_o(got.c1x), .first_ctrl_y_o(got.c1y),
    .split_x_o(got.px), .split_y_o(got.py),
    .second_ctrl_x_o(got.c2x), .second_ctrl_y_o(got.c2y),
    .first_fallback_o(got.fb1), .second_fallback_o(got.fb2)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint halve_sum(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Ray from a toward at meets ray from b toward bt; returns 0 when they do not meet ahead of both.
  function automatic logic ray_meet(longint ax, longint ay, longint atx, longint aty,
                                    longint bx, longint by, longint btx, longint bty,
                                    output longint ox, output longint oy);
    wide_t dx, dy, adx, ady, bdx, bdy, det, nu, nv, mx, my;
    logic [159:0] ad, q;
    longint qx, qy;
    logic sd;
    dx = bx - ax; dy = by - ay;
    adx = atx - ax; ady = aty - ay;
    bdx = btx - bx; bdy = bty - by;
    det = bdx * ady - bdy * adx;
    nu = dy * bdx - dx * bdy;
    nv = dy * adx - dx * ady;
    ox = 0; oy = 0;
    if (det == 0) return 1'b0;
    sd = det[159];
    if (nu == 0 || nu[159] != sd) return 1'b0;
    if (nv == 0 || nv[159] != sd) return 1'b0;
    ad = sd ? -det : det;
    mx = adx * nu;
    my = ady * nu;
    q = (mx[159] ? -mx : mx) / ad;
    if (q > (160'd1 << 62)) q = 160'd1 << 62;
    qx = longint'(q[63:0]);
    q = (my[159] ? -my : my) / ad;
    if (q > (160'd1 << 62)) q = 160'd1 << 62;
    qy = longint'(q[63:0]);
    if (mx[159] != sd) qx = -qx;
    if (my[159] != sd) qy = -qy;
    ox = clamp_coord(ax + qx);
    oy = clamp_coord(ay + qy);
    return 1'b1;
  endfunction

  function automatic quads_t split_cubic(cubic_t c);
    quads_t r;
    longint sx, sy, nx, ny, fx, fy, ex, ey;
    longint m0x, m0y, m1x, m1y, m2x, m2y, t0x, t0y, t1x, t1y, px, py;
    longint c1x, c1y, c2x, c2y;
    sx = c.sx; sy = c.sy; nx = c.nx; ny = c.ny;
    fx = c.fx; fy = c.fy; ex = c.ex; ey = c.ey;
    m0x = halve_sum(sx, nx); m0y = halve_sum(sy, ny);
    m1x = halve_sum(nx, fx); m1y = halve_sum(ny, fy);
    m2x = halve_sum(fx, ex); m2y = halve_sum(fy, ey);
    t0x = halve_sum(m0x, m1x); t0y = halve_sum(m0y, m1y);
    t1x = halve_sum(m1x, m2x); t1y = halve_sum(m1y, m2y);
    px = halve_sum(t0x, t1x); py = halve_sum(t0y, t1y);
    r.fb1 = !ray_meet(sx, sy, nx, ny, t1x, t1y, t0x, t0y, c1x, c1y);
    r.fb2 = !ray_meet(ex, ey, fx, fy, t0x, t0y, t1x, t1y, c2x, c2y);
    if (r.fb1) begin
      c1x = halve_sum(sx, px); c1y = halve_sum(sy, py);
    end
    if (r.fb2) begin
      c2x = halve_sum(px, ex); c2y = halve_sum(py, ey);
    end
    r.c1x = c1x[31:0]; r.c1y = c1y[31:0];
    r.px = px[31:0]; r.py = py[31:0];
    r.c2x = c2x[31:0]; r.c2y = c2y[31:0];
    return r;
  endfunction

  function automatic coord_t near_val(coord_t base, int span);
    return base + coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic cubic_t random_cubic();
    cubic_t c;
    int kind;
    int span;
    kind = $urandom_range(9);
    span = 1 << $urandom_range(4, 24);
    c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (kind)
      0, 1: begin
      end
      2, 3, 4, 5: begin
        c.sx = near_val(0, span); c.sy = near_val(0, span);
        c.nx = near_val(0, span); c.ny = near_val(0, span);
        c.fx = near_val(0, span); c.fy = near_val(0, span);
        c.ex = near_val(0, span); c.ey = near_val(0, span);
      end
      6: begin
        c.sx = near_val(0, span); c.sy = near_val(0, span);
        c.ex = near_val(0, span); c.ey = near_val(0, span);
        c.nx = c.sx + (c.ex - c.sx) / 3; c.ny = c.sy + (c.ey - c.sy) / 3;
        c.fx = c.sx + 2 * ((c.ex - c.sx) / 3); c.fy = c.sy + 2 * ((c.ey - c.sy) / 3);
      end
      7: begin
        c.nx = $urandom_range(1) ? c.sx : c.fx;
        c.ny = $urandom_range(1) ? c.sy : c.fy;
        if ($urandom_range(1)) begin
          c.fx = c.ex; c.fy = c.ey;
        end
      end
      default: begin
        // Nearly straight curve at large scale drives the control far away.
        c.sx = 32'sh8000_0000 + coord_t'($urandom_range(255));
        c.sy = near_val(0, 64);
        c.ex = 32'sh7fff_ffff - coord_t'($urandom_range(255));
        c.ey = near_val(0, 64);
        c.nx = near_val(-32'sd1000000000, 1 << 20); c.ny = near_val(c.sy, 8);
        c.fx = near_val(32'sd1000000000, 1 << 20); c.fy = near_val(c.ey, 8);
      end
    endcase
    return c;
  endfunction

  initial begin
    cubic_t c;
    pending_curves.insert(pending_curves.size(), '0);
    pending_curves.insert(pending_curves.size(), {8{32'sh7fff_ffff}});
    pending_curves.insert(pending_curves.size(), {8{32'sh8000_0000}});
    pending_curves.insert(pending_curves.size(),
                          {32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
    pending_curves.insert(pending_curves.size(),
                          {32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000});
    pending_curves.insert(pending_curves.size(),
                          {32'sd0, 32'sd0, 32'sh1_0000, 32'sh2_0000,
                           32'sh3_0000, 32'sh2_0000, 32'sh4_0000, 32'sd0});
    pending_curves.insert(pending_curves.size(),
                          {32'sd0, 32'sd0, 32'sh1_0000, 32'sh1_0000,
                           32'sh2_0000, 32'sh2_0000, 32'sh3_0000, 32'sh3_0000});
    pending_curves.insert(pending_curves.size(),
                          {32'sd0, 32'sd0, 32'sh4_0000, 32'sh4_0000,
                           32'sd0, 32'sh4_0000, 32'sh4_0000, 32'sd0});
    pending_curves.insert(pending_curves.size(),
                          {32'sd0, 32'sd0, -32'sh1_0000, 32'sd0,
                           32'sh5_0000, 32'sh1_0000, 32'sh4_0000, 32'sd0});
    pending_curves.insert(pending_curves.size(),
                          {32'sd5, -32'sd7, 32'sd5, -32'sd7,
                           32'sd9, 32'sd3, 32'sd9, 32'sd3});
    pending_curves.insert(pending_curves.size(),
                          {-32'sd3, -32'sd3, 32'sd1, 32'sd2,
                           -32'sd1, 32'sd2, 32'sd3, -32'sd3});
    pending_curves.insert(pending_curves.size(),
                          {32'sh8000_0000, 32'sd0, -32'sd1000000000, 32'sd1,
                           32'sd1000000000, 32'sd1, 32'sh7fff_ffff, 32'sd0});
    pending_curves.insert(pending_curves.size(),
                          {32'sd0, 32'sh8000_0000, -32'sd1, -32'sd1000000000,
                           32'sd1, 32'sd1000000000, 32'sd0, 32'sh7fff_ffff});
    pending_curves.insert(pending_curves.size(),
                          {32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                           32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555});
    for (int i = 0; i < 8; i++) begin
      c = random_cubic();
      pending_curves.insert(pending_curves.size(), c);
    end
    for (int i = 0; i < 1030; i++) begin
      c = random_cubic();
      pending_curves.insert(pending_curves.size(), c);
    end
    wait (pending_curves.size() == 0 && !in_valid_i);
    wait (expected_quads.size() == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cubic_to_two_quadratics: match");
    end else begin
      $display("cubic_to_two_quadratics: mismatch");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (cycle_count == 11) begin
      rst_ni <= 1'b1;
    end
    if (rst_ni && (!in_valid_i || took)) begin
      took = 1'b0;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_curves.size() > 0) begin
        burst_left--;
        curve_d <= pending_curves.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (cycle_count % 97 == 0) begin
      stall_mode = $urandom_range(3);
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(1) == 0);
      2: out_ready_i <= ($urandom_range(7) == 0);
      default: out_ready_i <= (cycle_count % 5 != 0);
    endcase
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] have);
    if (want !== have) begin
      $error("%s: expected %h, got %h", name, want, have);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    quads_t want;
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("cubic_to_two_quadratics: mismatch");
      $finish;
    end else begin
      if (rst_ni && in_valid_i && in_ready_o) begin
        took = 1'b1;
        expected_quads.insert(expected_quads.size(), split_cubic(curve_d));
      end
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_quads.size() == 0) begin
          $error("result word with no curve pending");
          fail_count++;
        end else begin
          want = expected_quads.pop_front();
          check_field("first_ctrl_x", want.c1x, got.c1x);
          check_field("first_ctrl_y", want.c1y, got.c1y);
          check_field("split_x", want.px, got.px);
          check_field("split_y", want.py, got.py);
          check_field("second_ctrl_x", want.c2x, got.c2x);
          check_field("second_ctrl_y", want.c2y, got.c2y);
          check_field("first_fallback", {31'b0, want.fb1}, {31'b0, got.fb1});
          check_field("second_fallback", {31'b0, want.fb2}, {31'b0, got.fb2});
        end
      end
    end
  end

endmodule

>>> filelist.f
hdl/c2q_pkg.sv
hdl/cubic_to_two_quadratics.sv
tb/cubic_to_two_quadratics_test.sv
